// ===== rtl/core/halton_radical_inverse_2d_core_macros.svh =====
// Assertion helpers for the Halton point core.
`ifndef HALTON_RADICAL_INVERSE_2D_CORE_MACROS_SVH
`define HALTON_RADICAL_INVERSE_2D_CORE_MACROS_SVH

// Same-cycle implication, switched off while in reset
`define HRI_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while in reset
`define HRI_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hri_pkg.sv =====
`default_nettype none

package hri_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_ZERO = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RST_BASE_X    = 5'd2;
	localparam logic [CFG_DATA_W-1:0] RST_BASE_Y    = 5'd3;
	localparam logic                  RST_SKIP_ZERO = 1'b1;

	// Result precision and digit divider chunk (bits per cycle)
	localparam int FRAC_W  = 32;
	localparam int CHUNK_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_FRAC
	} hri_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic digit_run;
		logic frac_init;
		logic frac_run;
		logic push;
	} hri_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic digits_done;
		logic frac_last;
	} hri_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/hri_ctrl.sv =====
`default_nettype none

module hri_ctrl import hri_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         out_busy,
	input  hri_status_t status,
	output logic        ready,
	output hri_cmd_t    cmd
);

	hri_state_t state_q;
	hri_state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (status.digits_done) state_nx = ST_FRAC;
			end
			ST_FRAC: begin
				if (status.frac_last && !out_busy) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		ready = 1'b0;
		cmd   = '0;
		case (state_q)
			ST_IDLE: begin
				ready    = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIGIT: begin
				if (status.digits_done) begin
					cmd.frac_init = 1'b1;
				end else begin
					cmd.digit_run = 1'b1;
				end
			end
			ST_FRAC: begin
				// last bit waits until the output register is free
				cmd.frac_run = !status.frac_last || !out_busy;
				cmd.push     = status.frac_last && !out_busy;
			end
			default: begin
				ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/hri_datapath.sv =====
`default_nettype none

module hri_datapath import hri_pkg::*; #(
	parameter int INDEX_WIDTH = 32,
	parameter int MAX_BASE    = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  hri_cmd_t              cmd,
	input  wire [INDEX_WIDTH-1:0] index,
	input  wire [CFG_DATA_W-1:0]  base_x,
	input  wire [CFG_DATA_W-1:0]  base_y,
	input  wire                   skip_zero,
	output hri_status_t           status,
	output logic [FRAC_W-1:0]     x_res,
	output logic [FRAC_W-1:0]     y_res
);

	localparam int NW      = INDEX_WIDTH + 1;
	localparam int BW      = $clog2(MAX_BASE + 1);
	localparam int DW      = NW + BW;
	localparam int NCH     = (NW + CHUNK_W - 1) / CHUNK_W;
	localparam int NP      = NCH * CHUNK_W;
	localparam int CNT_TOP = (NCH + 1 > FRAC_W) ? NCH + 1 : FRAC_W;
	localparam int CW      = $clog2(CNT_TOP);

	logic [CW-1:0]         cnt_q;
	logic [NW-1:0]         n_load;
	logic [CFG_DATA_W-1:0] raw [2];
	logic [FRAC_W-1:0]     res [2];
	logic [1:0]            lane_zero;

	// Clamp a base register into 2..MAX_BASE
	function automatic logic [BW-1:0] clamp_base(input logic [CFG_DATA_W-1:0] b);
		if (int'(b) < 2) return BW'(2);
		else if (int'(b) > MAX_BASE) return BW'(MAX_BASE);
		else return BW'(b);
	endfunction

	// Sample number, plus one when skip_zero is set, without wrap
	assign n_load = NW'(index) + NW'(skip_zero);
	assign raw[0] = base_x;
	assign raw[1] = base_y;
	assign x_res  = res[0];
	assign y_res  = res[1];

	// Shared step counter: digit rounds of NCH chunks plus one update, then fraction bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load || cmd.frac_init) begin
			cnt_q <= '0;
		end else if (cmd.digit_run) begin
			cnt_q <= (cnt_q == CW'(NCH)) ? '0 : cnt_q + 1'b1;
		end else if (cmd.frac_run) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign status.digits_done = (cnt_q == '0) && (&lane_zero);
	assign status.frac_last   = (cnt_q == CW'(FRAC_W - 1));

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [BW-1:0]      base_q;
		logic [NW-1:0]      num_q;
		logic [NP-1:0]      sh_q;
		logic [NP-1:0]      qt_q;
		logic [BW-1:0]      rm_q;
		logic [DW-1:0]      rev_q;
		logic [DW-1:0]      den_q;
		logic [DW-1:0]      rem_q;
		logic [FRAC_W-1:0]  frac_q;
		logic [CHUNK_W-1:0] qb;
		logic [BW-1:0]      rm_nx;
		logic [DW+BW-1:0]   rev_prod;
		logic [DW+BW-1:0]   den_prod;
		logic [DW:0]        r2;
		logic [DW:0]        r2_diff;
		logic               fb;
		logic [DW-1:0]      rem_nx;

		// One chunk of the digit division: CHUNK_W restoring steps on a narrow remainder
		always_comb begin
			logic [BW:0]   t;
			logic [BW-1:0] r;
			r  = rm_q;
			qb = '0;
			for (int j = 0; j < CHUNK_W; j++) begin
				t = {r, sh_q[NP-1-j]};
				if (t >= {1'b0, base_q}) begin
					t                 = t - {1'b0, base_q};
					qb[CHUNK_W-1-j]   = 1'b1;
				end
				r = t[BW-1:0];
			end
			rm_nx = r;
		end

		// Digit packing: rev = rev*b + d, den = den*b
		assign rev_prod = (DW+BW)'(rev_q) * (DW+BW)'(base_q) + (DW+BW)'(rm_q);
		assign den_prod = (DW+BW)'(den_q) * (DW+BW)'(base_q);

		// One bit of rev/den long division
		assign r2      = {rem_q, 1'b0};
		assign r2_diff = r2 - {1'b0, den_q};
		assign fb      = (r2 >= {1'b0, den_q});
		assign rem_nx  = fb ? r2_diff[DW-1:0] : r2[DW-1:0];

		assign lane_zero[l] = (num_q == '0);
		assign res[l]       = {frac_q[FRAC_W-2:0], fb};

		always_ff @(posedge clk) begin
			if (cmd.load) begin
				base_q <= clamp_base(raw[l]);
				num_q  <= n_load;
				sh_q   <= NP'(n_load);
				rm_q   <= '0;
				rev_q  <= '0;
				den_q  <= DW'(1);
			end else if (cmd.digit_run && !lane_zero[l]) begin
				if (cnt_q == CW'(NCH)) begin
					// round end: quotient becomes the new number
					num_q <= qt_q[NW-1:0];
					sh_q  <= qt_q;
					rm_q  <= '0;
					rev_q <= rev_prod[DW-1:0];
					den_q <= den_prod[DW-1:0];
				end else begin
					sh_q <= sh_q << CHUNK_W;
					qt_q <= {qt_q[NP-CHUNK_W-1:0], qb};
					rm_q <= rm_nx;
				end
			end else if (cmd.frac_init) begin
				rem_q <= rev_q;
			end else if (cmd.frac_run) begin
				rem_q  <= rem_nx;
				frac_q <= {frac_q[FRAC_W-2:0], fb};
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/halton_radical_inverse_2d_core.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------
// in      | in_valid / in_stall  | index
// out     | out_valid / out_stall| x_frac, y_frac
// cfg     | cfg_we               | cfg_addr, cfg_wdata
//
// One item at a time. Each base-digit round walks NCH = ceil((INDEX_WIDTH+1)/8)
// chunks and then one update; rounds run until the numbers of both axes reach zero,
// and then the fraction bits follow.
// The digit divider takes 8 index bits a cycle; the fraction divider one bit a cycle, but for a stalled last bit.
// Reset puts the controller idle, empties the output register, loads the reset bases.
// A stalled result holds the last fraction bit until the output register frees;
// a new item is taken while a finished result still waits.
`default_nettype none
`include "halton_radical_inverse_2d_core_macros.svh"

module halton_radical_inverse_2d_core import hri_pkg::*; #(
	parameter int INDEX_WIDTH = 32,
	parameter int MAX_BASE    = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_addr,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire [INDEX_WIDTH-1:0] index,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [FRAC_W-1:0]     x_frac,
	output logic [FRAC_W-1:0]     y_frac
);

	logic [CFG_DATA_W-1:0] base_x_q;
	logic [CFG_DATA_W-1:0] base_y_q;
	logic                  skip_zero_q;
	logic                  out_valid_q;
	logic [FRAC_W-1:0]     x_q;
	logic [FRAC_W-1:0]     y_q;
	logic [FRAC_W-1:0]     x_res;
	logic [FRAC_W-1:0]     y_res;
	logic                  ready;
	logic                  out_busy;
	logic                  cmd_work;
	hri_cmd_t              cmd;
	hri_status_t           status;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q    <= RST_BASE_X;
			base_y_q    <= RST_BASE_Y;
			skip_zero_q <= RST_SKIP_ZERO;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BASE_X:    base_x_q    <= cfg_wdata;
				REG_BASE_Y:    base_y_q    <= cfg_wdata;
				REG_SKIP_ZERO: skip_zero_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	hri_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.status   (status),
		.ready    (ready),
		.cmd      (cmd)
	);

	hri_datapath #(
		.INDEX_WIDTH (INDEX_WIDTH),
		.MAX_BASE    (MAX_BASE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.index     (index),
		.base_x    (base_x_q),
		.base_y    (base_y_q),
		.skip_zero (skip_zero_q),
		.status    (status),
		.x_res     (x_res),
		.y_res     (y_res)
	);

	// Output register
	assign out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			x_q <= x_res;
			y_q <= y_res;
		end
	end

	assign in_stall  = !ready;
	assign out_valid = out_valid_q;
	assign x_frac    = x_q;
	assign y_frac    = y_q;

	// datapath busy with digit, fraction or push work
	assign cmd_work = cmd.push || cmd.frac_run || cmd.digit_run;

	// Checks
	`HRI_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall, "not busy")
	`HRI_ASSERT_IMP(a_push_slot_free, clk, arst_n, cmd.push, !out_busy, "push over a stalled item")
	`HRI_ASSERT_NXT(a_push_shows, clk, arst_n, cmd.push, out_valid_q, "pushed result not shown")
	`HRI_ASSERT_IMP(a_load_alone, clk, arst_n, cmd.load, !cmd_work, "load overlaps datapath work")

endmodule

`default_nettype wire
